/* rtl/core/rid_pkg.sv */
// Package for the instruction decoder: field widths, mnemonic and operand
// format codes, result struct and the opcode/function/rt decode tables.
// No dependencies.
package rid_pkg;

    localparam int WORD_W   = 32;
    localparam int OP_W     = 6;
    localparam int REG_W    = 5;
    localparam int SA_W     = 5;
    localparam int IMM_W    = 16;
    localparam int TGT_W    = 26;
    localparam int MNEM_W   = 7;
    localparam int FMT_W    = 4;

    localparam logic [OP_W-1:0] OP_SPECIAL = 6'd0;
    localparam logic [OP_W-1:0] OP_REGIMM  = 6'd1;

    typedef enum logic [FMT_W-1:0] {
        F_NONE, F_RD_RT_SA, F_RD_RT_RS, F_RS, F_RD_RS, F_RD_RS_RT, F_RD,
        F_RS_RT, F_RS_OFF, F_RS_IMM, F_TARGET, F_RS_RT_OFF, F_RT_RS_IMM,
        F_RT_IMM, F_RT_MEM
    } t_fmt;

    typedef enum logic [MNEM_W-1:0] {
        M_NOP, M_SLL, M_SRL, M_SRA, M_SLLV, M_SRLV, M_SRAV, M_JR, M_JALR,
        M_MOVZ, M_MOVN, M_SYSCALL, M_BREAK, M_SYNC, M_MFHI, M_MTHI, M_MFLO,
        M_MTLO, M_DSLLV, M_DSRLV, M_DSRAV, M_MULT, M_MULTU, M_DIV, M_DIVU,
        M_DMULT, M_DMULTU, M_DDIV, M_DDIVU, M_ADD, M_ADDU, M_SUB, M_SUBU,
        M_AND, M_OR, M_XOR, M_NOR, M_SLT, M_SLTU, M_DADD, M_DADDU, M_DSUB,
        M_DSUBU, M_TGE, M_TGEU, M_TLT, M_TLTU, M_TEQ,
        M_BLTZ, M_BGEZ, M_BLTZL, M_TGEI, M_TGEIU, M_TLTI, M_TLTIU, M_TEQI,
        M_TNEI, M_BLTZAL, M_BGEZAL, M_BLTZALL, M_BGEZALL,
        M_J, M_JAL, M_BEQ, M_BNE, M_BLEZ, M_BGTZ, M_ADDI, M_ADDIU, M_SLTI,
        M_SLTIU, M_ANDI, M_ORI, M_XORI, M_LUI, M_BEQL, M_BNEL, M_BLEZL,
        M_BGTZL, M_DADDI, M_DADDIU, M_LDL, M_LDR, M_OP31, M_LB, M_LH, M_LWL,
        M_LW, M_LBU, M_LHU, M_LWR, M_LWU, M_SB, M_SH, M_SWL, M_SW, M_SDL,
        M_SDR, M_SWR, M_LL, M_LLD, M_LD, M_SC, M_SCD, M_SD
    } t_mnem;

    typedef struct packed {
        logic  ok;
        t_mnem code;
        t_fmt  fmt;
    } t_dec;

    typedef struct packed {
        logic              valid_res;
        logic [MNEM_W-1:0] mnemonic_code;
        logic [FMT_W-1:0]  operand_format;
        logic [REG_W-1:0]  reg_d;
        logic [REG_W-1:0]  reg_s;
        logic [REG_W-1:0]  reg_t;
        logic [SA_W-1:0]   shift_amount;
        logic [IMM_W-1:0]  immediate;
        logic [TGT_W-1:0]  jump_target;
        logic [OP_W-1:0]   primary_opcode;
    } t_result;

    localparam t_dec DEC_NONE = '{ok: 1'b0, code: M_NOP, fmt: F_NONE};

    function automatic t_dec f_ent(t_mnem code, t_fmt fmt);
        f_ent = '{ok: 1'b1, code: code, fmt: fmt};
    endfunction

    // opcode 0, by function field
    function automatic t_dec f_funct(logic [5:0] fn);
        t_dec e;
        unique case (fn)
            6'd0:  e = f_ent(M_SLL,     F_RD_RT_SA);
            6'd2:  e = f_ent(M_SRL,     F_RD_RT_SA);
            6'd3:  e = f_ent(M_SRA,     F_RD_RT_SA);
            6'd4:  e = f_ent(M_SLLV,    F_RD_RT_RS);
            6'd6:  e = f_ent(M_SRLV,    F_RD_RT_RS);
            6'd7:  e = f_ent(M_SRAV,    F_RD_RT_RS);
            6'd8:  e = f_ent(M_JR,      F_RS);
            6'd9:  e = f_ent(M_JALR,    F_RD_RS);
            6'd10: e = f_ent(M_MOVZ,    F_RD_RS_RT);
            6'd11: e = f_ent(M_MOVN,    F_RD_RS_RT);
            6'd12: e = f_ent(M_SYSCALL, F_NONE);
            6'd13: e = f_ent(M_BREAK,   F_NONE);
            6'd15: e = f_ent(M_SYNC,    F_NONE);
            6'd16: e = f_ent(M_MFHI,    F_RD);
            6'd17: e = f_ent(M_MTHI,    F_RS);
            6'd18: e = f_ent(M_MFLO,    F_RD);
            6'd19: e = f_ent(M_MTLO,    F_RS);
            6'd20: e = f_ent(M_DSLLV,   F_RD_RT_RS);
            6'd22: e = f_ent(M_DSRLV,   F_RD_RT_RS);
            6'd23: e = f_ent(M_DSRAV,   F_RD_RT_RS);
            6'd24: e = f_ent(M_MULT,    F_RS_RT);
            6'd25: e = f_ent(M_MULTU,   F_RS_RT);
            6'd26: e = f_ent(M_DIV,     F_RS_RT);
            6'd27: e = f_ent(M_DIVU,    F_RS_RT);
            6'd28: e = f_ent(M_DMULT,   F_RS_RT);
            6'd29: e = f_ent(M_DMULTU,  F_RS_RT);
            6'd30: e = f_ent(M_DDIV,    F_RS_RT);
            6'd31: e = f_ent(M_DDIVU,   F_RS_RT);
            6'd32: e = f_ent(M_ADD,     F_RD_RS_RT);
            6'd33: e = f_ent(M_ADDU,    F_RD_RS_RT);
            6'd34: e = f_ent(M_SUB,     F_RD_RS_RT);
            6'd35: e = f_ent(M_SUBU,    F_RD_RS_RT);
            6'd36: e = f_ent(M_AND,     F_RD_RS_RT);
            6'd37: e = f_ent(M_OR,      F_RD_RS_RT);
            6'd38: e = f_ent(M_XOR,     F_RD_RS_RT);
            6'd39: e = f_ent(M_NOR,     F_RD_RS_RT);
            6'd42: e = f_ent(M_SLT,     F_RD_RS_RT);
            6'd43: e = f_ent(M_SLTU,    F_RD_RS_RT);
            6'd44: e = f_ent(M_DADD,    F_RD_RS_RT);
            6'd45: e = f_ent(M_DADDU,   F_RD_RS_RT);
            6'd46: e = f_ent(M_DSUB,    F_RD_RS_RT);
            6'd47: e = f_ent(M_DSUBU,   F_RD_RS_RT);
            6'd48: e = f_ent(M_TGE,     F_RS_RT);
            6'd49: e = f_ent(M_TGEU,    F_RS_RT);
            6'd50: e = f_ent(M_TLT,     F_RS_RT);
            6'd51: e = f_ent(M_TLTU,    F_RS_RT);
            6'd52: e = f_ent(M_TEQ,     F_RS_RT);
            default: e = DEC_NONE;
        endcase
        return e;
    endfunction

    // opcode 1, by rt field
    function automatic t_dec f_regimm(logic [REG_W-1:0] rt);
        t_dec e;
        unique case (rt)
            5'd0:  e = f_ent(M_BLTZ,    F_RS_OFF);
            5'd1:  e = f_ent(M_BGEZ,    F_RS_OFF);
            5'd2:  e = f_ent(M_BLTZL,   F_RS_OFF);
            5'd8:  e = f_ent(M_TGEI,    F_RS_IMM);
            5'd9:  e = f_ent(M_TGEIU,   F_RS_IMM);
            5'd10: e = f_ent(M_TLTI,    F_RS_IMM);
            5'd11: e = f_ent(M_TLTIU,   F_RS_IMM);
            5'd12: e = f_ent(M_TEQI,    F_RS_IMM);
            5'd14: e = f_ent(M_TNEI,    F_RS_IMM);
            5'd16: e = f_ent(M_BLTZAL,  F_RS_OFF);
            5'd17: e = f_ent(M_BGEZAL,  F_RS_OFF);
            5'd18: e = f_ent(M_BLTZALL, F_RS_OFF);
            5'd19: e = f_ent(M_BGEZALL, F_RS_OFF);
            default: e = DEC_NONE;
        endcase
        return e;
    endfunction

    // all other primary opcodes
    function automatic t_dec f_opcode(logic [OP_W-1:0] op);
        t_dec e;
        unique case (op)
            6'd2:  e = f_ent(M_J,      F_TARGET);
            6'd3:  e = f_ent(M_JAL,    F_TARGET);
            6'd4:  e = f_ent(M_BEQ,    F_RS_RT_OFF);
            6'd5:  e = f_ent(M_BNE,    F_RS_RT_OFF);
            6'd6:  e = f_ent(M_BLEZ,   F_RS_OFF);
            6'd7:  e = f_ent(M_BGTZ,   F_RS_OFF);
            6'd8:  e = f_ent(M_ADDI,   F_RT_RS_IMM);
            6'd9:  e = f_ent(M_ADDIU,  F_RT_RS_IMM);
            6'd10: e = f_ent(M_SLTI,   F_RT_RS_IMM);
            6'd11: e = f_ent(M_SLTIU,  F_RT_RS_IMM);
            6'd12: e = f_ent(M_ANDI,   F_RT_RS_IMM);
            6'd13: e = f_ent(M_ORI,    F_RT_RS_IMM);
            6'd14: e = f_ent(M_XORI,   F_RT_RS_IMM);
            6'd15: e = f_ent(M_LUI,    F_RT_IMM);
            6'd20: e = f_ent(M_BEQL,   F_RS_RT_OFF);
            6'd21: e = f_ent(M_BNEL,   F_RS_RT_OFF);
            6'd22: e = f_ent(M_BLEZL,  F_RS_OFF);
            6'd23: e = f_ent(M_BGTZL,  F_RS_OFF);
            6'd24: e = f_ent(M_DADDI,  F_RT_RS_IMM);
            6'd25: e = f_ent(M_DADDIU, F_RT_RS_IMM);
            6'd26: e = f_ent(M_LDL,    F_RT_MEM);
            6'd27: e = f_ent(M_LDR,    F_RT_MEM);
            6'd31: e = f_ent(M_OP31,   F_RT_MEM);
            6'd32: e = f_ent(M_LB,     F_RT_MEM);
            6'd33: e = f_ent(M_LH,     F_RT_MEM);
            6'd34: e = f_ent(M_LWL,    F_RT_MEM);
            6'd35: e = f_ent(M_LW,     F_RT_MEM);
            6'd36: e = f_ent(M_LBU,    F_RT_MEM);
            6'd37: e = f_ent(M_LHU,    F_RT_MEM);
            6'd38: e = f_ent(M_LWR,    F_RT_MEM);
            6'd39: e = f_ent(M_LWU,    F_RT_MEM);
            6'd40: e = f_ent(M_SB,     F_RT_MEM);
            6'd41: e = f_ent(M_SH,     F_RT_MEM);
            6'd42: e = f_ent(M_SWL,    F_RT_MEM);
            6'd43: e = f_ent(M_SW,     F_RT_MEM);
            6'd44: e = f_ent(M_SDL,    F_RT_MEM);
            6'd45: e = f_ent(M_SDR,    F_RT_MEM);
            6'd46: e = f_ent(M_SWR,    F_RT_MEM);
            6'd48: e = f_ent(M_LL,     F_RT_MEM);
            6'd52: e = f_ent(M_LLD,    F_RT_MEM);
            6'd55: e = f_ent(M_LD,     F_RT_MEM);
            6'd56: e = f_ent(M_SC,     F_RT_MEM);
            6'd60: e = f_ent(M_SCD,    F_RT_MEM);
            6'd63: e = f_ent(M_SD,     F_RT_MEM);
            default: e = DEC_NONE;
        endcase
        return e;
    endfunction

endpackage

/* rtl/core/rid_if.sv */
// Stream interfaces for the instruction decoder: instruction beats in,
// decoded result beats out. Depends on rid_pkg.
interface rid_in_if import rid_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] instr_word;

    modport source (output valid, output instr_word, input ready);
    modport sink   (input valid, input instr_word, output ready);
endinterface

interface rid_out_if import rid_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              valid_res;
    logic [MNEM_W-1:0] mnemonic_code;
    logic [FMT_W-1:0]  operand_format;
    logic [REG_W-1:0]  reg_d;
    logic [REG_W-1:0]  reg_s;
    logic [REG_W-1:0]  reg_t;
    logic [SA_W-1:0]   shift_amount;
    logic [IMM_W-1:0]  immediate;
    logic [TGT_W-1:0]  jump_target;
    logic [OP_W-1:0]   primary_opcode;

    modport source (
        output valid, output valid_res, output mnemonic_code, output operand_format,
        output reg_d, output reg_s, output reg_t, output shift_amount,
        output immediate, output jump_target, output primary_opcode,
        input ready
    );
    modport sink (
        input valid, input valid_res, input mnemonic_code, input operand_format,
        input reg_d, input reg_s, input reg_t, input shift_amount,
        input immediate, input jump_target, input primary_opcode,
        output ready
    );
endinterface

/* rtl/core/risc_instruction_decoder_unit.sv */
// Instruction decoder top level: input register, decode tables, result register.
// Depends on rid_pkg and the rid_in_if / rid_out_if interfaces.
//
// Takes one 32-bit instruction beat per cycle while the output is not stalled and
// returns one result beat per instruction, via the input and result registers. The
// word is captured in an input register; the decode (primary opcode, then
// function field for opcode 0 or rt field for opcode 1) is a single table
// lookup feeding the result register. The input register moves on whenever the
// result register is empty or is taken in the same cycle, so a full pipeline
// keeps accepting while the result is taken every cycle.
// Unrecognized words give valid_res = 0 with mnemonic and format zero; the
// raw fields are always the plain bit slices of the word.
module risc_instruction_decoder_unit import rid_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    rid_in_if.sink     i_dec_in,
    rid_out_if.source  o_dec_out
);

    logic              r_in_vld;
    logic [WORD_W-1:0] r_word;
    logic              r_out_vld;
    t_result           r_res;
    t_result           n_res;
    t_dec              dec;
    logic              s1_move;
    logic              in_take;

    assign s1_move         = r_in_vld && (!r_out_vld || o_dec_out.ready);
    assign in_take         = i_dec_in.valid && i_dec_in.ready;
    assign i_dec_in.ready  = !r_in_vld || s1_move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (s1_move) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_word <= i_dec_in.instr_word;
        end
    end

    always_comb begin
        if (r_word[31:26] == OP_SPECIAL) begin
            // all-zero register fields with function zero is nop
            if (r_word[25:11] == '0 && r_word[5:0] == '0) begin
                dec = f_ent(M_NOP, F_NONE);
            end else begin
                dec = f_funct(r_word[5:0]);
            end
        end else if (r_word[31:26] == OP_REGIMM) begin
            dec = f_regimm(r_word[20:16]);
        end else begin
            dec = f_opcode(r_word[31:26]);
        end
    end

    always_comb begin
        n_res.valid_res      = dec.ok;
        n_res.mnemonic_code  = dec.ok ? dec.code : M_NOP;
        n_res.operand_format = dec.ok ? dec.fmt  : F_NONE;
        n_res.reg_d          = r_word[15:11];
        n_res.reg_s          = r_word[25:21];
        n_res.reg_t          = r_word[20:16];
        n_res.shift_amount   = r_word[10:6];
        n_res.immediate      = r_word[15:0];
        n_res.jump_target    = r_word[25:0];
        n_res.primary_opcode = r_word[31:26];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_move) begin
            r_out_vld <= 1'b1;
        end else if (o_dec_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_res <= n_res;
        end
    end

    assign o_dec_out.valid          = r_out_vld;
    assign o_dec_out.valid_res      = r_res.valid_res;
    assign o_dec_out.mnemonic_code  = r_res.mnemonic_code;
    assign o_dec_out.operand_format = r_res.operand_format;
    assign o_dec_out.reg_d          = r_res.reg_d;
    assign o_dec_out.reg_s          = r_res.reg_s;
    assign o_dec_out.reg_t          = r_res.reg_t;
    assign o_dec_out.shift_amount   = r_res.shift_amount;
    assign o_dec_out.immediate      = r_res.immediate;
    assign o_dec_out.jump_target    = r_res.jump_target;
    assign o_dec_out.primary_opcode = r_res.primary_opcode;

    // input stalls only with both stages full
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_dec_in.ready |-> (r_in_vld && r_out_vld))
        else $error("input stalled with a free stage");

    // unrecognized beats carry zero mnemonic and format
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_res.valid_res) |->
            (r_res.mnemonic_code == M_NOP && r_res.operand_format == F_NONE))
        else $error("invalid result with nonzero codes");

    // nop only for the special opcode with all register fields zero
    a_nop_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_res.valid_res && r_res.mnemonic_code == M_NOP) |->
            (r_res.primary_opcode == OP_SPECIAL && r_res.reg_s == '0 &&
             r_res.reg_t == '0 && r_res.reg_d == '0 &&
             r_res.operand_format == F_NONE))
        else $error("nop decoded from a non-nop word");

    // a beat moved into the result stage is presented next cycle
    a_stage_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_move |=> r_out_vld)
        else $error("result stage lost a beat");

endmodule

/* verif/tb_top.sv */
// Testbench for risc_instruction_decoder_unit: drives instruction words and checks
// every decoded result beat against a local decode of the same word.
// Depends on rid_pkg, rid_in_if / rid_out_if and the decoder RTL.
`timescale 1ns / 100ps

module tb_top;
    import rid_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 80;

    class decode_scoreboard;
        t_result pending_decodes[$];
        int      errors;

        function new();
            errors = 0;
        endfunction

        function t_result decode_word(logic [WORD_W-1:0] w);
            t_result          r;
            bit               hit;
            t_mnem            m;
            t_fmt             f;
            logic [OP_W-1:0]  op;
            logic [5:0]       fn;
            logic [REG_W-1:0] rs, rt, rd;
            op  = w[31:26];
            rs  = w[25:21];
            rt  = w[20:16];
            rd  = w[15:11];
            fn  = w[5:0];
            hit = 1'b1;
            m   = M_NOP;
            f   = F_NONE;
            if (op == OP_SPECIAL) begin
                // function 0 with all registers zero stays nop
                if (!(fn == 6'd0 && {rs, rt, rd} == '0)) begin
                    case (fn)
                        6'd0, 6'd2, 6'd3: f = F_RD_RT_SA;
                        6'd4, 6'd6, 6'd7, 6'd20, 6'd22, 6'd23: f = F_RD_RT_RS;
                        6'd8, 6'd17, 6'd19: f = F_RS;
                        6'd9: f = F_RD_RS;
                        6'd10, 6'd11, 6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37,
                        6'd38, 6'd39, 6'd42, 6'd43, 6'd44, 6'd45, 6'd46,
                        6'd47: f = F_RD_RS_RT;
                        6'd12, 6'd13, 6'd15: f = F_NONE;
                        6'd16, 6'd18: f = F_RD;
                        6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd30, 6'd31,
                        6'd48, 6'd49, 6'd50, 6'd51, 6'd52: f = F_RS_RT;
                        default: hit = 1'b0;
                    endcase
                    case (fn)
                        6'd0:  m = M_SLL;
                        6'd2:  m = M_SRL;
                        6'd3:  m = M_SRA;
                        6'd4:  m = M_SLLV;
                        6'd6:  m = M_SRLV;
                        6'd7:  m = M_SRAV;
                        6'd8:  m = M_JR;
                        6'd9:  m = M_JALR;
                        6'd10: m = M_MOVZ;
                        6'd11: m = M_MOVN;
                        6'd12: m = M_SYSCALL;
                        6'd13: m = M_BREAK;
                        6'd15: m = M_SYNC;
                        6'd16: m = M_MFHI;
                        6'd17: m = M_MTHI;
                        6'd18: m = M_MFLO;
                        6'd19: m = M_MTLO;
                        6'd20: m = M_DSLLV;
                        6'd22: m = M_DSRLV;
                        6'd23: m = M_DSRAV;
                        default: begin
                            if (fn >= 6'd24 && fn <= 6'd39)
                                m = t_mnem'(int'(M_MULT) + int'(fn) - 24);
                            else if (fn >= 6'd42 && fn <= 6'd52)
                                m = t_mnem'(int'(M_SLT) + int'(fn) - 42);
                        end
                    endcase
                end
            end else if (op == OP_REGIMM) begin
                if (rt <= 5'd2) begin
                    m = t_mnem'(int'(M_BLTZ) + int'(rt));
                    f = F_RS_OFF;
                end else if (rt >= 5'd8 && rt <= 5'd12) begin
                    m = t_mnem'(int'(M_TGEI) + int'(rt) - 8);
                    f = F_RS_IMM;
                end else if (rt == 5'd14) begin
                    m = M_TNEI;
                    f = F_RS_IMM;
                end else if (rt >= 5'd16 && rt <= 5'd19) begin
                    m = t_mnem'(int'(M_BLTZAL) + int'(rt) - 16);
                    f = F_RS_OFF;
                end else begin
                    hit = 1'b0;
                end
            end else begin
                if (op <= 6'd15) begin
                    m = t_mnem'(int'(M_J) + int'(op) - 2);
                end else if (op >= 6'd20 && op <= 6'd27) begin
                    m = t_mnem'(int'(M_BEQL) + int'(op) - 20);
                end else if (op >= 6'd32 && op <= 6'd46) begin
                    m = t_mnem'(int'(M_LB) + int'(op) - 32);
                end else begin
                    case (op)
                        6'd31: m = M_OP31;
                        6'd48: m = M_LL;
                        6'd52: m = M_LLD;
                        6'd55: m = M_LD;
                        6'd56: m = M_SC;
                        6'd60: m = M_SCD;
                        6'd63: m = M_SD;
                        default: hit = 1'b0;
                    endcase
                end
                case (op)
                    6'd2, 6'd3: f = F_TARGET;
                    6'd4, 6'd5, 6'd20, 6'd21: f = F_RS_RT_OFF;
                    6'd6, 6'd7, 6'd22, 6'd23: f = F_RS_OFF;
                    6'd8, 6'd9, 6'd10, 6'd11, 6'd12, 6'd13, 6'd14, 6'd24,
                    6'd25: f = F_RT_RS_IMM;
                    6'd15: f = F_RT_IMM;
                    default: f = F_RT_MEM;
                endcase
            end
            r.valid_res      = hit;
            r.mnemonic_code  = hit ? m : '0;
            r.operand_format = hit ? f : '0;
            r.reg_d          = rd;
            r.reg_s          = rs;
            r.reg_t          = rt;
            r.shift_amount   = w[10:6];
            r.immediate      = w[15:0];
            r.jump_target    = w[25:0];
            r.primary_opcode = op;
            return r;
        endfunction

        function void note_instr(logic [WORD_W-1:0] w);
            pending_decodes.push_back(decode_word(w));
        endfunction

        function int pending_count();
            return pending_decodes.size();
        endfunction

        function bit field_ok(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (act_v !== exp_v) begin
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
                return 1'b0;
            end
            return 1'b1;
        endfunction

        function void check_result(t_result got);
            t_result want;
            bit      ok;
            if (pending_decodes.size() == 0) begin
                $display("%0t: result beat with nothing expected, expected none, got %h",
                         $time, got);
                errors++;
                return;
            end
            want = pending_decodes.pop_front();
            ok = 1'b1;
            ok &= field_ok("valid_res", want.valid_res, got.valid_res);
            ok &= field_ok("mnemonic_code", want.mnemonic_code, got.mnemonic_code);
            ok &= field_ok("operand_format", want.operand_format, got.operand_format);
            ok &= field_ok("reg_d", want.reg_d, got.reg_d);
            ok &= field_ok("reg_s", want.reg_s, got.reg_s);
            ok &= field_ok("reg_t", want.reg_t, got.reg_t);
            ok &= field_ok("shift_amount", want.shift_amount, got.shift_amount);
            ok &= field_ok("immediate", want.immediate, got.immediate);
            ok &= field_ok("jump_target", want.jump_target, got.jump_target);
            ok &= field_ok("primary_opcode", want.primary_opcode, got.primary_opcode);
            if (!ok)
                errors++;
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   cycles = 0;
    bit   steady = 1'b0;
    bit   hold_request = 1'b0;

    decode_scoreboard sb = new();

    rid_in_if  dec_in();
    rid_out_if dec_out();

    risc_instruction_decoder_unit u_top (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_dec_in  (dec_in),
        .o_dec_out (dec_out)
    );

    always begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic int draw_gap();
        return steady ? 0 : $urandom_range(0, 11);
    endfunction

    function automatic logic [WORD_W-1:0] rand_instr();
        logic [WORD_W-1:0] w;
        int                pick;
        w    = $urandom();
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            w[31:26] = OP_SPECIAL;
            if (pick < 4) begin
                w[25:11] = '0;
                w[5:0]   = 6'd0;
            end else if (pick < 8) begin
                w[5:0] = 6'd0;
                if (pick < 6)
                    w[25:16] = '0;
            end
        end else if (pick < 50) begin
            w[31:26] = OP_REGIMM;
        end else if (pick < 90) begin
            w[31:26] = OP_W'($urandom_range(2, 63));
        end
        return w;
    endfunction

    // entered right after an accepting edge, or after reset
    task automatic issue_instr(input logic [WORD_W-1:0] w, input int gap);
        if (gap > 0) begin
            dec_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        dec_in.valid      <= 1'b1;
        dec_in.instr_word <= w;
        @(posedge clk);
        while (!dec_in.ready) @(posedge clk);
        sb.note_instr(w);
    endtask

    task automatic drain();
        dec_in.valid <= 1'b0;
        do @(posedge clk); while (sb.pending_count() != 0);
    endtask

    initial begin : rx_side
        t_result got;
        int      hold;
        bit      held;
        held = 1'b0;
        dec_out.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            hold = draw_gap();
            if (hold_request && !held) begin
                held = 1'b1;
                hold = HOLD_CYCLES;
            end
            if (hold > 0) begin
                dec_out.ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            dec_out.ready <= 1'b1;
            @(posedge clk);
            while (!dec_out.valid) @(posedge clk);
            got.valid_res      = dec_out.valid_res;
            got.mnemonic_code  = dec_out.mnemonic_code;
            got.operand_format = dec_out.operand_format;
            got.reg_d          = dec_out.reg_d;
            got.reg_s          = dec_out.reg_s;
            got.reg_t          = dec_out.reg_t;
            got.shift_amount   = dec_out.shift_amount;
            got.immediate      = dec_out.immediate;
            got.jump_target    = dec_out.jump_target;
            got.primary_opcode = dec_out.primary_opcode;
            sb.check_result(got);
        end
    end

    initial begin : tx_side
        logic [WORD_W-1:0] directed_words [24];
        logic [WORD_W-1:0] w;
        directed_words = '{
            32'h0000_0000, 32'h0000_07C0, 32'h0000_0800, 32'h0020_0000,
            32'h0001_0000, 32'h03FF_FFC0, 32'h0000_0001, 32'h03FF_FFFF,
            32'h0000_0034, 32'h0000_0035, 32'h041F_0000, 32'h0400_0000,
            32'h0413_FFFF, 32'h0BFF_FFFF, 32'h0C00_0000, 32'h3C00_FFFF,
            32'h7C00_0000, 32'h4000_0000, 32'hBC00_0000, 32'hFFFF_FFFF,
            32'hFC00_0000, 32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555
        };
        rst_n             <= 1'b0;
        dec_in.valid      <= 1'b0;
        dec_in.instr_word <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_words[i])
            issue_instr(directed_words[i], draw_gap());

        // every function, rt and opcode selector with random remaining fields
        for (int fn = 0; fn < 64; fn++) begin
            w = $urandom();
            w[31:26] = OP_SPECIAL;
            w[5:0]   = 6'(fn);
            issue_instr(w, draw_gap());
        end
        for (int rt = 0; rt < 32; rt++) begin
            w = $urandom();
            w[31:26] = OP_REGIMM;
            w[20:16] = 5'(rt);
            issue_instr(w, draw_gap());
        end
        for (int op = 2; op < 64; op++) begin
            w = $urandom();
            w[31:26] = 6'(op);
            issue_instr(w, draw_gap());
        end

        repeat (350) issue_instr(rand_instr(), draw_gap());

        steady = 1'b1;
        repeat (250) issue_instr(rand_instr(), 0);
        steady = 1'b0;

        drain();
        hold_request = 1'b1;
        repeat (60) issue_instr(rand_instr(), 0);
        drain();

        repeat (370) issue_instr(rand_instr(), draw_gap());

        drain();
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending_count() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
